// ===== rtl/pis_pkg.sv =====
// pis_pkg: field widths, stream packing constants and the control struct
// shared by the phasor datapath and its top level
// no dependencies
`timescale 1ns / 1ps

package pis_pkg;

  // fixed field widths of the request and result items
  localparam int CH_W       = 4;
  localparam int INC_W      = 26;
  localparam int SYNC_W     = 26;
  localparam int OFF_W      = 28;
  localparam int PH_OUT_W   = 25;

  // stream packing
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam int INC_LSB    = 0;
  localparam int SYNC_LSB   = INC_LSB + INC_W;
  localparam int OFF_LSB    = SYNC_LSB + SYNC_W;

  // per-request control flags handed to the datapath
  typedef struct packed {
    logic soft_en;  // soft sync mode captured with the request
    logic synced;   // sync value in (0, 1]
    logic dir;      // stored direction, 1 = reverse
    logic inc_neg;  // increment below zero, wrap end at 0
  } pis_ctl_t;

endpackage

// ===== rtl/pis_core.sv =====
// pis_core: combinational phase update for one request
// offset fold, sync handling, wrap and impulse, next stored phase
// depends on pis_pkg
`timescale 1ns / 1ps

module pis_core #(
  parameter int FRAC_BITS = 24,
  parameter int CW        = 30,
  parameter int PW        = 27
) (
  input  pis_pkg::pis_ctl_t                ctl,
  input  logic signed [CW-1:0]             inc_clip,
  input  logic signed [CW-1:0]             trig,
  input  logic signed [pis_pkg::OFF_W-1:0] cur_offset,
  input  logic signed [pis_pkg::OFF_W-1:0] last_offset,
  input  logic signed [PW-1:0]             phase,
  output logic [pis_pkg::PH_OUT_W-1:0]     phase_out,
  output logic                             impulse,
  output logic signed [PW-1:0]             phase_nxt,
  output logic                             dir_nxt
);
  import pis_pkg::*;

  localparam logic signed [CW-1:0] OneVal =
    {{(CW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [CW-1:0] FracMask = OneVal - CW'(1);

  logic signed [CW-1:0] dev;
  logic signed [CW-1:0] dev_m;
  logic signed [CW-1:0] dev_f;
  logic signed [CW-1:0] step;
  logic signed [CW-1:0] p0;
  logic signed [CW-1:0] p_sum;
  logic signed [CW-1:0] p_adj;
  logic signed [CW-1:0] p_mod;
  logic signed [CW-1:0] p_wr;
  logic                 imp;

  // offset change folded into (-1, 1) by truncating remainder
  always_comb begin
    dev   = CW'(cur_offset) - CW'(last_offset);
    dev_m = dev & FracMask;
    if (dev[CW-1] && (dev_m != '0)) begin
      dev_f = dev_m | ~FracMask;
    end else begin
      dev_f = dev_m;
    end
  end

  // step follows the direction held before this request's sync
  always_comb begin
    if (ctl.soft_en && ctl.dir) begin
      step = -inc_clip;
    end else begin
      step = inc_clip;
    end
  end

  // sync, offset shift and wrap at the end chosen by the increment sign
  always_comb begin
    if (ctl.synced && !ctl.soft_en) begin
      p0 = trig;
    end else begin
      p0 = CW'(phase);
    end
    p_sum = p0 + dev_f;
    p_adj = p0;
    p_mod = '0;
    p_wr  = '0;
    imp   = 1'b0;
    if (!ctl.inc_neg) begin
      if (!ctl.synced) begin
        if ((dev_f != '0) && (p_sum <= CW'(0))) begin
          p_adj = p_sum + OneVal;
        end else begin
          p_adj = p_sum;
        end
      end
      imp   = (p_adj >= OneVal);
      p_mod = p_adj & FracMask;
      p_wr  = p_mod;
    end else begin
      if (ctl.synced) begin
        if (p0 == OneVal) begin
          p_adj = '0;
        end
      end else if (p_sum >= OneVal) begin
        p_adj = p_sum - OneVal;
      end else begin
        p_adj = p_sum;
      end
      imp   = (p_adj <= CW'(0));
      p_mod = p_adj & FracMask;
      if (p_mod == '0) begin
        p_wr = OneVal;
      end else begin
        p_wr = p_mod;
      end
    end
  end

  // results and next state
  assign phase_out = p_wr[PH_OUT_W-1:0];
  assign impulse   = imp;
  assign phase_nxt = PW'(p_wr + step);
  assign dir_nxt   = ctl.dir ^ (ctl.synced && ctl.soft_en);

endmodule

// ===== rtl/phasor_impulse_with_sync.sv =====
// phasor_impulse_with_sync: multichannel phasor top level with state memory
// stream ports, clearing sweep, request and result registers
// depends on pis_pkg and pis_core
`timescale 1ns / 1ps

// Multichannel phasor with an impulse on wrap and hard or soft sync. Each
// request carries a channel (in_tuser) and an increment, a sync value and a
// phase offset (in_tdata); each request gives exactly one result, the
// wrapped phase and the impulse flag. A request can be taken in every cycle,
// also back to back on one channel: the per-channel state lives in a
// NUM_CHANNELS-deep memory with a registered read, and the state that the
// request ahead writes is forwarded, so the rate is one request per cycle
// while the result stream is not stalled; a result passes the request
// register, then the result register, held there while out_tready is low. After
// reset the state memory is cleared channel by channel, during which in_tready
// stays low; configuration writes are taken at any time and should be made
// only while the block is idle. A channel at or above NUM_CHANNELS gives a
// zero result and leaves all state alone.

module phasor_impulse_with_sync #(
  parameter int NUM_CHANNELS = 16,
  parameter int FRAC_BITS    = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: soft_sync in bit 0
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data,
  // request stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: increment [25:0], sync_value [51:26], offset [79:52]
  input  logic [pis_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: channel [3:0], zeros above
  input  logic [pis_pkg::IN_USER_W-1:0]     in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: phase_out [24:0], impulse [25], zeros above
  output logic [pis_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import pis_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PW = FRAC_BITS + 3;
  localparam int CW = (FRAC_BITS + 4 > 30) ? FRAC_BITS + 4 : 30;
  localparam int MW = 1 + OFF_W + PW;
  localparam logic signed [CW-1:0] OneVal =
    {{(CW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // state word: direction, last offset, phase
  typedef struct packed {
    logic                    dir;
    logic signed [OFF_W-1:0] off;
    logic signed [PW-1:0]    phase;
  } pis_state_t;

  logic                    soft_sync_r;
  logic                    clearing_r;
  logic [AW-1:0]           clr_cnt_r;

  logic                    s1_v_r;
  logic                    s1_in_range_r;
  logic [AW-1:0]           s1_idx_r;
  logic                    s1_soft_r;
  logic                    s1_synced_r;
  logic                    s1_inc_neg_r;
  logic signed [CW-1:0]    s1_inc_r;
  logic signed [CW-1:0]    s1_trig_r;
  logic signed [OFF_W-1:0] s1_off_r;
  pis_state_t              rd_r;

  logic                    out_v_r;
  logic [PH_OUT_W-1:0]     out_phase_r;
  logic                    out_imp_r;

  logic [MW-1:0]           state_mem_r [NUM_CHANNELS];

  logic                    in_fire;
  logic                    advance;
  logic [31:0]             ch_ext;
  logic                    in_range;
  logic [AW-1:0]           in_idx;
  logic signed [CW-1:0]    inc_s;
  logic signed [CW-1:0]    inc_clip;
  logic signed [CW-1:0]    sync_s;
  logic                    synced;

  pis_ctl_t                ctl;
  logic [PH_OUT_W-1:0]     core_phase;
  logic                    core_imp;
  logic signed [PW-1:0]    core_phase_nxt;
  logic                    core_dir_nxt;

  logic                    upd_en;
  logic                    wr_en;
  logic [AW-1:0]           wr_idx;
  pis_state_t              upd_word;
  logic [MW-1:0]           wr_word;
  logic                    bypass;

  // handshakes
  assign cfg_ready  = 1'b1;
  assign advance    = !out_v_r || out_tready;
  assign in_tready  = !clearing_r && (!s1_v_r || advance);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W-PH_OUT_W-1){1'b0}}, out_imp_r, out_phase_r};

  // request decode: channel range, increment clip, sync window
  always_comb begin
    ch_ext   = 32'(in_tuser[CH_W-1:0]);
    in_range = (ch_ext < 32'(NUM_CHANNELS));
    in_idx   = in_range ? ch_ext[AW-1:0] : '0;
    inc_s    = CW'($signed(in_tdata[INC_LSB +: INC_W]));
    sync_s   = CW'($signed(in_tdata[SYNC_LSB +: SYNC_W]));
    if (inc_s > OneVal) begin
      inc_clip = OneVal;
    end else if (inc_s < -OneVal) begin
      inc_clip = -OneVal;
    end else begin
      inc_clip = inc_s;
    end
    synced = (sync_s > CW'(0)) && (sync_s <= OneVal);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_sync_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      soft_sync_r <= cfg_data;
    end
  end

  // clearing sweep over the state memory after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == AW'(NUM_CHANNELS - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // request register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_fire;
    end
  end

  // request register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_in_range_r <= in_range;
      s1_idx_r      <= in_idx;
      s1_soft_r     <= soft_sync_r;
      s1_synced_r   <= synced;
      s1_inc_neg_r  <= inc_s[CW-1];
      s1_inc_r      <= inc_clip;
      s1_trig_r     <= sync_s;
      s1_off_r      <= $signed(in_tdata[OFF_LSB +: OFF_W]);
    end
  end

  // datapath
  always_comb begin
    ctl.soft_en = s1_soft_r;
    ctl.synced  = s1_synced_r;
    ctl.dir     = rd_r.dir;
    ctl.inc_neg = s1_inc_neg_r;
  end

  pis_core #(
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW),
    .PW        (PW)
  ) u_core (
    .ctl          (ctl),
    .inc_clip     (s1_inc_r),
    .trig         (s1_trig_r),
    .cur_offset   (s1_off_r),
    .last_offset  (rd_r.off),
    .phase        (rd_r.phase),
    .phase_out    (core_phase),
    .impulse      (core_imp),
    .phase_nxt    (core_phase_nxt),
    .dir_nxt      (core_dir_nxt)
  );

  // state write port: clearing sweep or write-back of the advancing request
  always_comb begin
    upd_word.dir   = core_dir_nxt;
    upd_word.off   = s1_off_r;
    upd_word.phase = core_phase_nxt;
    upd_en         = s1_v_r && advance && s1_in_range_r;
    wr_en          = clearing_r || upd_en;
    wr_idx         = clearing_r ? clr_cnt_r : s1_idx_r;
    wr_word        = clearing_r ? '0 : upd_word;
    bypass         = upd_en && (s1_idx_r == in_idx);
  end

  // state memory write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem_r[wr_idx] <= wr_word;
    end
  end

  // state memory read, forwarding the write of the same edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (bypass) begin
        rd_r <= upd_word;
      end else begin
        rd_r <= state_mem_r[in_idx];
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= s1_v_r;
    end
  end

  // result register payload, zero for a channel out of range
  always_ff @(posedge clk) begin
    if (advance && s1_v_r) begin
      out_phase_r <= s1_in_range_r ? core_phase : '0;
      out_imp_r   <= s1_in_range_r && core_imp;
    end
  end

endmodule

// ===== rtl/pis_checker.sv =====
// pis_checker: port-level assertions for the phasor top level
// bound to phasor_impulse_with_sync; depends on pis_pkg
`timescale 1ns / 1ps

module pis_checker #(
  parameter int NUM_CHANNELS = 16,
  parameter int FRAC_BITS    = 24
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pis_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pis_pkg::*;

  localparam int LimW = PH_OUT_W + 1;
  localparam logic [LimW-1:0] PhaseLim =
    (FRAC_BITS < PH_OUT_W) ? (LimW'(1) << FRAC_BITS) : {LimW{1'b1}};

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // wrapped phase never exceeds one
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (LimW'(out_tdata[PH_OUT_W-1:0]) <= PhaseLim))
    else $error("phase out of range");

  // state clearing holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request taken before state clear");

  // an empty pipeline cannot show a result without a request
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid ##1 !$past(in_tvalid && in_tready) ##1 1'b1
      |-> !out_tvalid || $past(out_tvalid, 1) || $past(in_tvalid && in_tready, 2))
    else $error("result without request");

endmodule

bind phasor_impulse_with_sync pis_checker #(
  .NUM_CHANNELS (NUM_CHANNELS),
  .FRAC_BITS    (FRAC_BITS)
) u_pis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/phasor_impulse_with_sync_tb.sv =====
// phasor_impulse_with_sync_tb: self-checking bench for the multichannel phasor,
// a directed table then random phases in hard and soft sync mode
// depends on pis_pkg and phasor_impulse_with_sync
`timescale 1ns / 1ps

module phasor_impulse_with_sync_tb;
  import pis_pkg::*;

  localparam int NUM_CH         = 16;
  localparam int FRAC_BITS      = 24;
  localparam int UNIT           = 1 << FRAC_BITS;
  localparam int N_PHASES       = 6;
  localparam int PHASE_ITEMS    = 225;
  localparam int LONG_HOLD_AT   = 500;
  localparam int HOLD_CYCLES    = 300;
  localparam int LIMIT_CYCLES   = 200000;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    bit [CH_W-1:0]            channel;
    bit signed [INC_W-1:0]    increment;
    bit signed [SYNC_W-1:0]   sync_value;
    bit signed [OFF_W-1:0]    offset;
  } phasor_req_t;

  typedef struct {
    bit [PH_OUT_W-1:0] phase_out;
    bit                impulse;
  } phasor_res_t;

  // one table row: a request or a soft_sync write, with an optional fixed answer
  typedef struct {
    row_kind_t kind;
    int        channel;
    int        increment;
    int        sync_value;
    int        offset;
    bit        cfg_value;
    bit        typed;
    int        exp_phase;
    bit        exp_imp;
  } stim_row_t;

  localparam int N_DIRECTED = 27;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // fresh channel, nothing moves
    '{ROW_REQ, 0, 0, 0, 0, 1'b0, 1'b1, 0, 1'b0},
    // hard sync to exactly one wraps at once
    '{ROW_REQ, 1, 0, UNIT, 0, 1'b0, 1'b1, 0, 1'b1},
    // hard sync to one half
    '{ROW_REQ, 2, 0, UNIT / 2, 0, 1'b0, 1'b1, UNIT / 2, 1'b0},
    // largest increment clips to one, next sample wraps
    '{ROW_REQ, 3, 33554431, 0, 0, 1'b0, 1'b1, 0, 1'b0},
    '{ROW_REQ, 3, 0, 0, 0, 1'b0, 1'b1, 0, 1'b1},
    // most negative increment: wrap end at zero
    '{ROW_REQ, 4, -33554432, 0, 0, 1'b0, 1'b1, UNIT, 1'b1},
    // negative increment synced to one drops to zero
    '{ROW_REQ, 5, -1, UNIT, 0, 1'b0, 1'b1, UNIT, 1'b1},
    // sync values outside (0, 1] and the smallest sync
    '{ROW_REQ, 6, 1000, 33554431, 0, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 6, 1000, -33554432, 0, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 6, 1000, UNIT + 1, 0, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 6, -1000, 1, 0, 1'b0, 1'b0, 0, 1'b0},
    // offset extremes, large changes folded into (-1, 1)
    '{ROW_REQ, 7, 0, 0, 134217727, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 7, 0, 0, -134217728, 1'b0, 1'b0, 0, 1'b0},
    // offset change of exactly minus one, then a small negative change
    '{ROW_REQ, 8, 0, 0, -UNIT, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 8, 0, 0, -17000000, 1'b0, 1'b0, 0, 1'b0},
    // top channel, increment at plus and minus one
    '{ROW_REQ, 15, UNIT, 0, 0, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 15, -UNIT, 0, 0, 1'b0, 1'b0, 0, 1'b0},
    // negative increment with an offset change
    '{ROW_REQ, 9, -2000000, 0, 3000000, 1'b0, 1'b0, 0, 1'b0},
    // soft sync: direction flips, then the phase runs off the far end
    '{ROW_CFG, 0, 0, 0, 0, 1'b1, 1'b0, 0, 1'b0},
    '{ROW_REQ, 10, 4000000, 0, 0, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 10, 4000000, UNIT / 2, 0, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 10, 4000000, 0, 0, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 10, 4000000, 0, 0, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 10, 4000000, 0, 0, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 11, -4000000, UNIT, 0, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_REQ, 11, -4000000, 0, 0, 1'b0, 1'b0, 0, 1'b0},
    '{ROW_CFG, 0, 0, 0, 0, 1'b0, 1'b0, 0, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_data = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic [IN_USER_W-1:0]   in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;

  // mirror of the per-channel state and the mode register
  longint                 phase_acc [NUM_CH];
  bit signed [OFF_W-1:0]  last_offset [NUM_CH];
  bit                     reverse_dir [NUM_CH];
  bit                     soft_mode;

  phasor_res_t            pending_phasor_out [$];
  int                     mismatch_count = 0;
  int                     results_seen = 0;
  int                     cycle_count = 0;
  bit                     idle_on = 1'b1;
  bit                     sink_hold = 1'b0;

  phasor_impulse_with_sync #(
    .NUM_CHANNELS(NUM_CH),
    .FRAC_BITS   (FRAC_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // increment, sync_value, offset from bit 0
    .in_tuser  (in_tuser),   // channel, zeros above
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)   // phase_out, impulse, zeros above
  );

  always #2 clk = ~clk;

  // phase step for one sample: offset shift, sync, wrap, then the next phase
  function automatic phasor_res_t advance_phasor(input phasor_req_t req);
    int          ch;
    longint      inc;
    longint      trig;
    longint      dev;
    longint      step;
    longint      p;
    bit          synced;
    bit          imp;
    phasor_res_t res;
    ch = int'(req.channel);
    res.phase_out = '0;
    res.impulse = 1'b0;
    if (ch >= NUM_CH) return res;
    inc = longint'(req.increment);
    if (inc > UNIT) inc = UNIT;
    else if (inc < -UNIT) inc = -UNIT;
    trig = longint'(req.sync_value);
    dev = longint'(req.offset) - longint'(last_offset[ch]);
    if (dev >= UNIT || dev <= -UNIT) dev = dev % UNIT;
    // direction held before this sample's sync
    step = (soft_mode && reverse_dir[ch]) ? -inc : inc;
    p = phase_acc[ch];
    synced = trig > 0 && trig <= UNIT;
    if (synced) begin
      if (soft_mode) reverse_dir[ch] = ~reverse_dir[ch];
      else p = trig;
    end
    if (inc >= 0) begin
      if (!synced) begin
        p += dev;
        if (dev != 0 && p <= 0) p += UNIT;
      end
      imp = p >= UNIT;
      p = p % UNIT;
      if (p < 0) p += UNIT;
    end else begin
      if (synced && p == UNIT) p = 0;
      if (!synced) begin
        p += dev;
        if (p >= UNIT) p -= UNIT;
      end
      imp = p <= 0;
      p = p % UNIT;
      if (p <= 0) p += UNIT;
    end
    res.phase_out = PH_OUT_W'(p);
    res.impulse = imp;
    phase_acc[ch] = p + step;
    last_offset[ch] = req.offset;
    return res;
  endfunction

  // offer one request, after a random gap while gaps are on, record its answer once taken
  task automatic offer_request(input phasor_req_t req, input bit typed,
                               input phasor_res_t typed_res);
    int          gap;
    bit          acc;
    phasor_res_t predicted;
    gap = (idle_on && !sink_hold) ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {req.offset, req.sync_value, req.increment};
    in_tuser  <= IN_USER_W'(req.channel);
    do begin
      @(negedge clk);
      acc = in_tready;
      @(posedge clk);
    end while (!acc);
    predicted = advance_phasor(req);
    pending_phasor_out.push_back(typed ? typed_res : predicted);
  endtask

  // mode write once every result is out and the pipe has settled
  task automatic set_soft_sync(input bit mode);
    bit acc;
    in_tvalid <= 1'b0;
    while (pending_phasor_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    soft_mode = mode;
  endtask

  // result side: random stalls, one long hold, field checks
  initial begin : result_sink
    phasor_res_t got;
    phasor_res_t want;
    int          stall;
    bit          acc;
    bit          hold_done;
    hold_done = 1'b0;
    forever begin
      if (results_seen == LONG_HOLD_AT && !hold_done) begin
        sink_hold = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
        hold_done = 1'b1;
      end
      stall = idle_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        acc = out_tvalid;
        got.phase_out = out_tdata[PH_OUT_W-1:0];
        got.impulse = out_tdata[PH_OUT_W];
        @(posedge clk);
      end while (!acc);
      results_seen++;
      if (pending_phasor_out.size() == 0) begin
        $error("unexpected result: phase_out %0d impulse %0d", got.phase_out, got.impulse);
        mismatch_count++;
      end else begin
        want = pending_phasor_out.pop_front();
        if (got.phase_out !== want.phase_out) begin
          $error("phase_out: expected %0d, actual %0d", want.phase_out, got.phase_out);
          mismatch_count++;
        end
        if (got.impulse !== want.impulse) begin
          $error("impulse: expected %0d, actual %0d", want.impulse, got.impulse);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus: reset, directed table, random phases, drain
  initial begin : stimulus
    phasor_req_t req;
    phasor_res_t fixed_res;
    phasor_res_t no_res;
    longint      v;
    int          ch;
    no_res.phase_out = '0;
    no_res.impulse = 1'b0;
    soft_mode = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        set_soft_sync(directed_rows[i].cfg_value);
      end else begin
        req.channel = CH_W'(directed_rows[i].channel);
        req.increment = INC_W'(directed_rows[i].increment);
        req.sync_value = SYNC_W'(directed_rows[i].sync_value);
        req.offset = OFF_W'(directed_rows[i].offset);
        fixed_res.phase_out = PH_OUT_W'(directed_rows[i].exp_phase);
        fixed_res.impulse = directed_rows[i].exp_imp;
        offer_request(req, directed_rows[i].typed, fixed_res);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_soft_sync(ph % 2 == 1);
      idle_on = (ph != 2 && ph != 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // a few hot channels so back-to-back hits on one channel are common
        ch = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, NUM_CH - 1);
        req.channel = CH_W'(ch);

        // increment: mostly small steps for frequent wraps, plus edges and clipping
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: v = $urandom_range(1, 1 << 22);
          5:             v = 0;
          6:             v = UNIT;
          7:             v = $urandom;
          8:             v = UNIT + $urandom_range(1, UNIT - 1);
          default:       v = $urandom_range(1, 16);
        endcase
        if ($urandom_range(0, 1)) v = -v;
        req.increment = INC_W'(v);

        // sync value: usually none, then inside, at the edges and outside (0, 1]
        case ($urandom_range(0, 9))
          7:       v = $urandom_range(1, UNIT);
          8:       v = $urandom_range(0, 1) ? UNIT : 1;
          9:       v = $urandom_range(0, 1) ? longint'($urandom) : longint'(UNIT + 1);
          default: v = 0;
        endcase
        req.sync_value = SYNC_W'(v);

        // offset: mostly held, small drifts, whole-unit jumps and noise
        v = longint'(last_offset[ch]);
        case ($urandom_range(0, 9))
          6, 7:    v = v + $urandom_range(0, 1 << 21) - (1 << 20);
          8:       v = $urandom;
          9:       v = $urandom_range(0, 1) ? v + UNIT : v - UNIT;
          default: ;
        endcase
        req.offset = OFF_W'(v);

        offer_request(req, 1'b0, no_res);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_phasor_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
